>>> rtl/hidrs_pkg.sv
// Shared types, constants and helpers for the HID report descriptor scanner.
`default_nettype none

package hidrs_pkg;

    // Location record layout
    localparam int unsigned RECORD_BYTES    = 13;
    localparam int unsigned REC_MOUSE_EXIST = 0;
    localparam int unsigned REC_MOUSE_INTF  = 1;
    localparam int unsigned REC_MOUSE_RID   = 2;
    localparam int unsigned REC_BUTTON_BIT  = 3;
    localparam int unsigned REC_XY_INDEX    = 4;
    localparam int unsigned REC_XY_SIZE     = 5;
    localparam int unsigned REC_WHEEL_INDEX = 6;
    localparam int unsigned REC_WHEEL_SIZE  = 7;
    localparam int unsigned REC_PAN_INDEX   = 8;
    localparam int unsigned REC_PAN_SIZE    = 9;
    localparam int unsigned REC_KB_EXIST    = 10;
    localparam int unsigned REC_KB_INTF     = 11;
    localparam int unsigned REC_KB_RID      = 12;

    // Short item types
    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    // Main item tags
    localparam logic [3:0] TAG_INPUT      = 4'h8;
    localparam logic [3:0] TAG_COLLECTION = 4'hA;
    localparam logic [3:0] TAG_END_COLL   = 4'hC;

    // Global item tags
    localparam logic [3:0] TAG_USAGE_PAGE   = 4'h0;
    localparam logic [3:0] TAG_REPORT_SIZE  = 4'h7;
    localparam logic [3:0] TAG_REPORT_ID    = 4'h8;
    localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;

    // Local item tags
    localparam logic [3:0] TAG_USAGE = 4'h0;

    // Usage pages and usages
    localparam logic [7:0]  PAGE_GENERIC_DESKTOP = 8'h01;
    localparam logic [7:0]  PAGE_KEYBOARD        = 8'h07;
    localparam logic [7:0]  PAGE_BUTTON          = 8'h09;
    localparam logic [7:0]  PAGE_CONSUMER        = 8'h0C;
    localparam logic [7:0]  USAGE_POINTER        = 8'h01;
    localparam logic [7:0]  USAGE_MOUSE          = 8'h02;
    localparam logic [7:0]  USAGE_KEYBOARD       = 8'h06;
    localparam logic [15:0] USAGE_X              = 16'h0030;
    localparam logic [15:0] USAGE_Y              = 16'h0031;
    localparam logic [15:0] USAGE_Z              = 16'h0032;
    localparam logic [15:0] USAGE_WHEEL          = 16'h0038;
    localparam logic [15:0] USAGE_AC_PAN         = 16'h0238;

    localparam logic [7:0] UNSET = 8'hFF;

    // One descriptor byte transaction
    typedef struct packed {
        logic [7:0] desc_byte;
        logic       first_byte;
        logic       last_byte;
        logic       clear_record;
    } byte_xact_t;

    typedef logic [RECORD_BYTES-1:0][7:0] record_t;

    // Data byte count of a short item prefix; size code 3 means four bytes
    function automatic logic [2:0] item_size(input logic [7:0] hdr);
        item_size = (hdr[1:0] == 2'd3) ? 3'd4 : {1'b0, hdr[1:0]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/hidrs_parser.sv
// Byte-serial HID short item decoder and location record tracker.
`default_nettype none

module hidrs_parser
    import hidrs_pkg::*;
#(
    parameter int unsigned USAGE_SLOTS     = 8,
    parameter int unsigned REPORT_ID_SLOTS = 7,
    localparam int unsigned UCW = $clog2(USAGE_SLOTS + 1),
    localparam int unsigned UIW = $clog2(USAGE_SLOTS),
    localparam int unsigned RCW = $clog2(REPORT_ID_SLOTS + 1),
    localparam int unsigned RIW = (REPORT_ID_SLOTS > 1) ? $clog2(REPORT_ID_SLOTS) : 1
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             take,
    input  wire byte_xact_t                       xact,
    input  wire logic [7:0]                       intf_num,
    output logic                                  truncated_next,
    output record_t                               record_next,
    output logic [REPORT_ID_SLOTS-1:0][7:0]       rid_list_next,
    output logic [RCW-1:0]                        rid_count_next
);

    logic [2:0]  phase_reg,  phase_next,  phase_cur;
    logic [7:0]  header_reg, header_next, header_cur;
    logic [15:0] data_reg,   data_next,   data_cur;
    logic [15:0] bitpos_reg, bitpos_next, bitpos_cur;
    logic [7:0]  upage_reg,  upage_next,  upage_cur;
    logic [UCW-1:0] ucount_reg, ucount_next, ucount_cur;
    logic [7:0]  cusage_reg, cusage_next, cusage_cur;
    logic [7:0]  cpage_reg,  cpage_next,  cpage_cur;
    logic [7:0]  rid_reg,    rid_next,    rid_cur;
    logic [7:0]  rsize_reg,  rsize_next,  rsize_cur;
    logic [7:0]  rcount_reg, rcount_next, rcount_cur;
    logic [RCW-1:0] ridcnt_reg, ridcnt_cur;
    record_t     record_reg, record_cur;
    logic [USAGE_SLOTS-1:0][15:0]    ulist_reg, ulist_next;
    logic [REPORT_ID_SLOTS-1:0][7:0] ridlist_reg;

    logic        ex_go;
    logic [7:0]  ex_hdr;
    logic [15:0] ex_data;
    logic [2:0]  len;
    logic [2:0]  k;
    logic [7:0]  b0;
    logic [7:0]  byte_idx;
    logic [7:0]  wheel_tmp;
    logic [7:0]  wheel_q;
    logic signed [15:0] prod;
    logic        pointer_coll;

    always_comb
    begin
        // Start of descriptor clears parse state before the byte is taken
        phase_cur  = xact.first_byte ? 3'd0  : phase_reg;
        header_cur = xact.first_byte ? 8'd0  : header_reg;
        data_cur   = xact.first_byte ? 16'd0 : data_reg;
        bitpos_cur = xact.first_byte ? 16'd0 : bitpos_reg;
        upage_cur  = xact.first_byte ? UNSET : upage_reg;
        ucount_cur = xact.first_byte ? '0    : ucount_reg;
        cusage_cur = xact.first_byte ? UNSET : cusage_reg;
        cpage_cur  = xact.first_byte ? UNSET : cpage_reg;
        rid_cur    = xact.first_byte ? UNSET : rid_reg;
        rsize_cur  = xact.first_byte ? UNSET : rsize_reg;
        rcount_cur = xact.first_byte ? UNSET : rcount_reg;
        ridcnt_cur = xact.first_byte ? '0    : ridcnt_reg;
        record_cur = (xact.first_byte && xact.clear_record) ? {RECORD_BYTES{UNSET}} : record_reg;

        phase_next     = phase_cur;
        header_next    = header_cur;
        data_next      = data_cur;
        bitpos_next    = bitpos_cur;
        upage_next     = upage_cur;
        ucount_next    = ucount_cur;
        cusage_next    = cusage_cur;
        cpage_next     = cpage_cur;
        rid_next       = rid_cur;
        rsize_next     = rsize_cur;
        rcount_next    = rcount_cur;
        rid_count_next = ridcnt_cur;
        record_next    = record_cur;
        ulist_next     = ulist_reg;
        rid_list_next  = ridlist_reg;

        ex_go   = 1'b0;
        ex_hdr  = header_cur;
        ex_data = 16'd0;
        k       = 3'd0;

        // Prefix or data byte
        if (phase_cur == 3'd0)
        begin
            header_next = xact.desc_byte;
            data_next   = 16'd0;
            len         = item_size(xact.desc_byte);
            if (len == 3'd0)
            begin
                ex_go  = 1'b1;
                ex_hdr = xact.desc_byte;
            end
            else
            begin
                phase_next = len;
            end
        end
        else
        begin
            len = item_size(header_cur);
            k   = len - phase_cur;
            if (k == 3'd0)
                data_next = data_cur | {8'd0, xact.desc_byte};
            else if (k == 3'd1)
                data_next = data_cur | {xact.desc_byte, 8'd0};
            phase_next = phase_cur - 3'd1;
            if (phase_next == 3'd0)
            begin
                ex_go   = 1'b1;
                ex_data = data_next;
            end
        end

        // Item execution
        b0           = ex_data[7:0];
        byte_idx     = bitpos_cur[10:3];
        wheel_tmp    = rsize_cur + (rsize_cur[7] ? 8'd3 : 8'd0);
        wheel_q      = {{2{wheel_tmp[7]}}, wheel_tmp[7:2]};
        prod         = $signed(rsize_cur) * $signed(rcount_cur);
        pointer_coll = (cpage_cur == PAGE_GENERIC_DESKTOP) &&
                       (cusage_cur == USAGE_MOUSE || cusage_cur == USAGE_POINTER);

        if (ex_go)
        begin
            unique case (ex_hdr[3:2])
                TYPE_MAIN:
                begin
                    if (ex_hdr[7:4] == TAG_INPUT)
                    begin
                        if (!b0[0])
                        begin
                            if (pointer_coll)
                            begin
                                record_next[REC_MOUSE_EXIST] = 8'd1;
                                record_next[REC_MOUSE_INTF]  = intf_num;
                                record_next[REC_MOUSE_RID]   = rid_cur;
                                priority if (upage_cur == PAGE_BUTTON)
                                begin
                                    record_next[REC_BUTTON_BIT] = bitpos_cur[7:0];
                                    ucount_next = '0;
                                end
                                else if (upage_cur == PAGE_GENERIC_DESKTOP &&
                                         ucount_cur == UCW'(2) && rcount_cur == 8'd2 &&
                                         ulist_reg[0] == USAGE_X && ulist_reg[1] == USAGE_Y)
                                begin
                                    record_next[REC_XY_INDEX] = byte_idx;
                                    record_next[REC_XY_SIZE]  = rsize_cur;
                                    ucount_next = '0;
                                end
                                else if (upage_cur == PAGE_GENERIC_DESKTOP &&
                                         ucount_cur == UCW'(3) && rcount_cur == 8'd3 &&
                                         ulist_reg[0] == USAGE_X && ulist_reg[1] == USAGE_Y &&
                                         (ulist_reg[2] == USAGE_WHEEL ||
                                          ulist_reg[2] == USAGE_Z))
                                begin
                                    // wheel sits after X/Y: index + size/4 toward zero
                                    record_next[REC_XY_INDEX]    = byte_idx;
                                    record_next[REC_XY_SIZE]     = rsize_cur;
                                    record_next[REC_WHEEL_SIZE]  = rsize_cur;
                                    record_next[REC_WHEEL_INDEX] = byte_idx + wheel_q;
                                    ucount_next = '0;
                                end
                                else if (upage_cur == PAGE_GENERIC_DESKTOP &&
                                         ucount_cur == UCW'(1) && rcount_cur == 8'd1 &&
                                         ulist_reg[0] == USAGE_WHEEL)
                                begin
                                    record_next[REC_WHEEL_INDEX] = byte_idx;
                                    record_next[REC_WHEEL_SIZE]  = rsize_cur;
                                    ucount_next = '0;
                                end
                                else if (upage_cur == PAGE_CONSUMER &&
                                         ucount_cur == UCW'(1) && rcount_cur == 8'd1 &&
                                         ulist_reg[0] == USAGE_AC_PAN)
                                begin
                                    record_next[REC_PAN_INDEX] = byte_idx;
                                    record_next[REC_PAN_SIZE]  = rsize_cur;
                                    ucount_next = '0;
                                end
                            end
                            else if (cpage_cur == PAGE_GENERIC_DESKTOP &&
                                     cusage_cur == USAGE_KEYBOARD &&
                                     upage_cur == PAGE_KEYBOARD)
                            begin
                                record_next[REC_KB_EXIST] = 8'd1;
                                record_next[REC_KB_INTF]  = intf_num;
                                record_next[REC_KB_RID]   = rid_cur;
                            end
                        end
                        bitpos_next = bitpos_cur + prod;
                        if (ridcnt_cur < RCW'(REPORT_ID_SLOTS))
                        begin
                            rid_list_next[ridcnt_cur[RIW-1:0]] = rid_cur;
                            rid_count_next = ridcnt_cur + RCW'(1);
                        end
                    end
                    else if (ex_hdr[7:4] == TAG_COLLECTION)
                    begin
                        cpage_next = upage_cur;
                        if (ucount_cur != '0)
                            cusage_next = ulist_reg[0][7:0];
                        ucount_next = '0;
                    end
                    else if (ex_hdr[7:4] == TAG_END_COLL)
                    begin
                        rid_next    = UNSET;
                        ucount_next = '0;
                        upage_next  = UNSET;
                    end
                end
                TYPE_GLOBAL:
                begin
                    unique case (ex_hdr[7:4])
                        TAG_USAGE_PAGE:   upage_next  = b0;
                        TAG_REPORT_SIZE:  rsize_next  = b0;
                        TAG_REPORT_ID:    rid_next    = b0;
                        TAG_REPORT_COUNT: rcount_next = b0;
                        default:          ;
                    endcase
                end
                TYPE_LOCAL:
                begin
                    // one-byte usage already holds only its low byte
                    if (ex_hdr[7:4] == TAG_USAGE && ucount_cur < UCW'(USAGE_SLOTS))
                    begin
                        ulist_next[ucount_cur[UIW-1:0]] = ex_data;
                        ucount_next = ucount_cur + UCW'(1);
                    end
                end
                default: ;
            endcase
        end

        truncated_next = (phase_next != 3'd0);
        if (xact.last_byte)
            phase_next = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 3'd0;
            header_reg <= 8'd0;
            data_reg   <= 16'd0;
            bitpos_reg <= 16'd0;
            upage_reg  <= UNSET;
            ucount_reg <= '0;
            cusage_reg <= UNSET;
            cpage_reg  <= UNSET;
            rid_reg    <= UNSET;
            rsize_reg  <= UNSET;
            rcount_reg <= UNSET;
            ridcnt_reg <= '0;
            record_reg <= {RECORD_BYTES{UNSET}};
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            data_reg   <= data_next;
            bitpos_reg <= bitpos_next;
            upage_reg  <= upage_next;
            ucount_reg <= ucount_next;
            cusage_reg <= cusage_next;
            cpage_reg  <= cpage_next;
            rid_reg    <= rid_next;
            rsize_reg  <= rsize_next;
            rcount_reg <= rcount_next;
            ridcnt_reg <= rid_count_next;
            record_reg <= record_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ulist_reg   <= ulist_next;
            ridlist_reg <= rid_list_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hid_report_descriptor_scanner.sv
// Top level of the HID report descriptor scanner: stream ports, APB register, result dump.
// Latency: a descriptor byte is decoded at the edge that accepts it; the result run for a
//   last byte starts in the next cycle and gives 13 + REPORT_ID_SLOTS entries, one per cycle
//   while m_tready is high. Throughput: one byte per cycle; a last byte waits only while the
//   previous run is still draining (it may enter as that run's final entry leaves).
// Reset: parse state to defaults, location record to all 0xFF, interface_number to 0.
`default_nettype none

module hid_report_descriptor_scanner
    import hidrs_pkg::*;
#(
    parameter int unsigned USAGE_SLOTS     = 8,
    parameter int unsigned REPORT_ID_SLOTS = 7
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] desc_byte
    input  wire logic        s_tlast,   // last_byte
    input  wire logic [1:0]  s_tuser,   // [0] first_byte, [1] clear_record
    // result stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [4:0] entry_index, [12:5] entry_value, [15:13] zero
    output logic             m_tlast,   // last_of_run
    output logic             m_tuser,   // truncated
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned RCW     = $clog2(REPORT_ID_SLOTS + 1);
    localparam int unsigned RIW     = (REPORT_ID_SLOTS > 1) ? $clog2(REPORT_ID_SLOTS) : 1;
    localparam int unsigned ENTRIES = RECORD_BYTES + REPORT_ID_SLOTS;
    localparam logic [4:0]  LAST_ENTRY = 5'(ENTRIES - 1);

    // interface_number register; only one register, so every address maps to it
    logic [7:0] intf_reg, intf_next;

    assign pready = 1'b1;
    assign prdata = {24'd0, intf_reg};

    always_comb
    begin
        intf_next = intf_reg;
        if (psel && penable && pwrite && pready)
            intf_next = pwdata[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            intf_reg <= 8'd0;
        else
            intf_reg <= intf_next;
    end

    // Decoder
    byte_xact_t                      xact;
    logic                            take;
    logic                            trunc_next;
    record_t                         record_next;
    logic [REPORT_ID_SLOTS-1:0][7:0] rid_list_next;
    logic [RCW-1:0]                  rid_count_next;

    assign xact.desc_byte    = s_tdata;
    assign xact.first_byte   = s_tuser[0];
    assign xact.last_byte    = s_tlast;
    assign xact.clear_record = s_tuser[1];

    assign take = s_tvalid && s_tready;

    hidrs_parser #(
        .USAGE_SLOTS     (USAGE_SLOTS),
        .REPORT_ID_SLOTS (REPORT_ID_SLOTS)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .xact           (xact),
        .intf_num       (intf_reg),
        .truncated_next (trunc_next),
        .record_next    (record_next),
        .rid_list_next  (rid_list_next),
        .rid_count_next (rid_count_next)
    );

    // Result run: the record and list are captured on the last byte so that
    // parsing of the next descriptor can go on while the run drains.
    logic                            busy_reg, busy_next;
    logic [4:0]                      idx_reg, idx_next;
    logic                            trunc_reg;
    record_t                         rec_snap_reg;
    logic [REPORT_ID_SLOTS-1:0][7:0] list_snap_reg;
    logic [RCW-1:0]                  cnt_snap_reg;
    logic                            out_take;
    logic                            run_done;
    logic                            load;
    logic [4:0]                      list_off;
    logic [7:0]                      entry_value;

    assign out_take = m_tvalid && m_tready;
    assign run_done = out_take && (idx_reg == LAST_ENTRY);
    assign s_tready = !busy_reg || !s_tlast || run_done;
    assign load     = take && s_tlast;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 5'd0;
        end
        else if (out_take)
        begin
            idx_next = idx_reg + 5'd1;
            if (run_done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            trunc_reg     <= trunc_next;
            rec_snap_reg  <= record_next;
            list_snap_reg <= rid_list_next;
            cnt_snap_reg  <= rid_count_next;
        end
    end

    // Entry select: record bytes first, then report ID list (unwritten slots read 0xFF)
    assign list_off = idx_reg - 5'(RECORD_BYTES);

    always_comb
    begin
        if (idx_reg < 5'(RECORD_BYTES))
            entry_value = rec_snap_reg[idx_reg[3:0]];
        else if (5'(cnt_snap_reg) > list_off)
            entry_value = list_snap_reg[list_off[RIW-1:0]];
        else
            entry_value = UNSET;
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {3'd0, entry_value, idx_reg};
    assign m_tlast  = (idx_reg == LAST_ENTRY);
    assign m_tuser  = trunc_reg;

endmodule

`default_nettype wire
